/* sv/hta_pkg.sv */
// Shared types and constants for the heartbeat timeout alarm.
package hta_pkg;

  localparam int NUM_CHANNELS_DEF = 8;
  localparam int TIME_BITS_DEF    = 32;

  localparam int MASK_W     = 8;
  localparam int PRI_W      = 4;
  localparam int CLS_W      = 2;
  localparam int ID_W       = 3;
  localparam int TMO_W      = 16;
  localparam int CNT_W      = 6;
  localparam int BEEP_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MASK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZ_TONE    = 3'd6;

  localparam logic REQ_HEARTBEAT = 1'b0;
  localparam logic REQ_DETECT    = 1'b1;

  localparam logic [CLS_W-1:0] CLS_THREE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_FIVE  = 2'd2;

  localparam logic [CNT_W-1:0] FAULT_WRAP     = 6'd50;
  localparam logic [CNT_W-1:0] FAULT_ON_LIMIT = 6'd15;
  localparam logic [CNT_W-1:0] BLINK_WRAP     = 6'd50;
  localparam logic [CNT_W-1:0] HIT_0 = 6'd1;
  localparam logic [CNT_W-1:0] HIT_1 = 6'd7;
  localparam logic [CNT_W-1:0] HIT_2 = 6'd13;
  localparam logic [CNT_W-1:0] HIT_3 = 6'd19;
  localparam logic [CNT_W-1:0] HIT_4 = 6'd25;

  typedef struct packed {
    logic [MASK_W-1:0]     enable_mask;
    logic [TMO_W-1:0]      timeout_ms;
    logic [TMO_W-1:0]      long_timeout_ms;
    logic [MASK_W-1:0]     long_timeout_mask;
    logic [MASK_W*PRI_W-1:0] priority_table;
    logic [MASK_W*CLS_W-1:0] pattern_class;
    logic [TMO_W-1:0]      buzz_tone;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable_mask:       8'd63,
    timeout_ms:        16'd500,
    long_timeout_ms:   16'd2000,
    long_timeout_mask: 8'd32,
    priority_table:    32'h0015_4327,
    pattern_class:     16'h02A9,
    buzz_tone:         16'd1000
  };

  typedef struct packed {
    logic        req_type;
    logic [2:0]  channel;
    logic [31:0] now_ms;
    logic        global_fault;
  } in_t;

  typedef struct packed {
    logic [7:0]  offline_mask;
    logic        alarm_valid;
    logic [2:0]  alarm_channel;
    logic        led_red;
    logic [14:0] beep_level;
  } out_t;

  typedef struct packed {
    logic              valid;
    logic [PRI_W-1:0]  best_pri;
    logic [ID_W-1:0]   best_id;
    logic [MASK_W-1:0] off;
  } scan_t;

endpackage

/* sv/heartbeat_timeout_alarm.sv */
// Heartbeat timeout alarm: top level with configuration registers and the channel cell chain.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one request beat:
//   a heartbeat stamps now_ms into its channel's cell if that channel is enabled, a detect step checks ages,
//   updates offline mask and alarm, and steps the blink or fault pattern.
//   Every request yields one result beat on out_valid_o / out_stall_i / out_data_o.
//   A detect beat walks the cell chain one cell per cycle; at the chain's tail the
//   alarm state is updated and the result is then loaded into the output register.
//   A heartbeat passes through a write state before its result is registered.
//   The next beat is taken only once the sequencer is back in idle.
//   One request is in flight at a time; a result waiting in the output register
//   does not block the next request, but a stalled receiver holds the following
//   result in the sequencer and keeps in_stall_o high until the output frees up.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at once; the
//   user is to issue them only while the block is idle, which the block itself does
//   not enforce; unknown indexes are ignored. Reset clears last-seen times, counters,
//   alarm state and the output valid flag, and loads default configuration values.
module heartbeat_timeout_alarm #(
  parameter int NUM_CHANNELS = hta_pkg::NUM_CHANNELS_DEF,
  parameter int TIME_BITS    = hta_pkg::TIME_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [hta_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [hta_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  hta_pkg::in_t                        in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output hta_pkg::out_t                       out_data_o
);
  import hta_pkg::*;

  cfg_t                 cfg_q;
  logic [TIME_BITS-1:0] now;
  logic                 hb_we;
  logic [2:0]           hb_ch;
  scan_t                chain [NUM_CHANNELS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ENABLE_MASK:  cfg_q.enable_mask       <= cfg_data_i[MASK_W-1:0];
        CFG_TIMEOUT:      cfg_q.timeout_ms        <= cfg_data_i[TMO_W-1:0];
        CFG_LONG_TIMEOUT: cfg_q.long_timeout_ms   <= cfg_data_i[TMO_W-1:0];
        CFG_LONG_MASK:    cfg_q.long_timeout_mask <= cfg_data_i[MASK_W-1:0];
        CFG_PRIORITY:     cfg_q.priority_table    <= cfg_data_i[MASK_W*PRI_W-1:0];
        CFG_PATTERN:      cfg_q.pattern_class     <= cfg_data_i[MASK_W*CLS_W-1:0];
        CFG_BUZZ_TONE:    cfg_q.buzz_tone         <= cfg_data_i[TMO_W-1:0];
        default: ;
      endcase
    end
  end

  hta_ctrl #(
    .TIME_BITS(TIME_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .now_o       (now),
    .hb_we_o     (hb_we),
    .hb_ch_o     (hb_ch),
    .scan_head_o (chain[0]),
    .scan_tail_i (chain[NUM_CHANNELS])
  );

  for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_cell
    hta_cell #(
      .IDX       (g),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cfg_i   (cfg_q),
      .now_i   (now),
      .hb_we_i (hb_we),
      .hb_ch_i (hb_ch),
      .scan_i  (chain[g]),
      .scan_o  (chain[g+1])
    );
  end

endmodule

/* sv/hta_cell.sv */
// One channel cell: last-seen time, timeout check and priority compare along the chain.
module hta_cell #(
  parameter int IDX       = 0,
  parameter int TIME_BITS = hta_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hta_pkg::cfg_t        cfg_i,
  input  logic [TIME_BITS-1:0] now_i,
  input  logic                 hb_we_i,
  input  logic [2:0]           hb_ch_i,
  input  hta_pkg::scan_t       scan_i,
  output hta_pkg::scan_t       scan_o
);
  import hta_pkg::*;

  localparam bit IN_RANGE = IDX < MASK_W;
  localparam int LIDX     = IDX % MASK_W;
  localparam logic [ID_W-1:0] MY_ID = ID_W'(IDX % MASK_W);

  logic [TIME_BITS-1:0] last_seen_q;
  logic [TIME_BITS-1:0] age;
  logic [31:0]          age_w, lim_w;
  logic                 en, is_long, offline;
  logic [PRI_W-1:0]     pri;
  scan_t                scan_d, scan_q;

  assign en      = IN_RANGE && cfg_i.enable_mask[LIDX];
  assign is_long = IN_RANGE && cfg_i.long_timeout_mask[LIDX];
  assign pri     = IN_RANGE ? cfg_i.priority_table[PRI_W*LIDX +: PRI_W] : '0;
  assign age     = now_i - last_seen_q;
  assign age_w   = 32'(age);
  assign lim_w   = 32'(is_long ? cfg_i.long_timeout_ms : cfg_i.timeout_ms);
  assign offline = en && (age_w > lim_w);

  always_comb begin
    scan_d = scan_i;
    if (offline) begin
      scan_d.off[LIDX] = 1'b1;
      if (pri > scan_i.best_pri) begin
        scan_d.best_pri = pri;
        scan_d.best_id  = MY_ID;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_seen_q <= '0;
      scan_q      <= '0;
    end else begin
      if (hb_we_i && en && (32'(hb_ch_i) == IDX)) begin
        last_seen_q <= now_i;
      end
      scan_q <= scan_d;
    end
  end

  assign scan_o = scan_q;

endmodule

/* sv/hta_ctrl.sv */
// Sequencer: item capture, alarm update, blink and fault patterns, output register.
module hta_ctrl #(
  parameter int TIME_BITS = hta_pkg::TIME_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hta_pkg::cfg_t        cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  hta_pkg::in_t         in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output hta_pkg::out_t        out_data_o,
  output logic [TIME_BITS-1:0] now_o,
  output logic                 hb_we_o,
  output logic [2:0]           hb_ch_o,
  output hta_pkg::scan_t       scan_head_o,
  input  hta_pkg::scan_t       scan_tail_i
);
  import hta_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_SCAN  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [TIME_BITS-1:0] now_q;
  logic [2:0]           ch_q;
  logic                 fault_q;
  logic                 start_q;
  logic                 accept;

  logic [MASK_W-1:0] offline_q, offline_d;
  logic              aset_q, aset_d;
  logic [ID_W-1:0]   aid_q, aid_d;
  logic [CNT_W-1:0]  blink_q, blink_d, blink_inc;
  logic [CNT_W-1:0]  fcnt_q, fcnt_d;
  logic              led_q, led_d;
  logic [BEEP_W-1:0] beep_q, beep_d, half_tune;
  logic [CLS_W-1:0]  cls;
  logic              hit3, hit5, upd;

  out_t out_q;
  logic out_valid_q, load_out;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = state_q != ST_IDLE;
  assign load_out   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);
  assign upd        = (state_q == ST_SCAN) && scan_tail_i.valid;

  assign now_o   = now_q;
  assign hb_ch_o = ch_q;
  assign hb_we_o = state_q == ST_WRITE;

  always_comb begin
    scan_head_o       = '0;
    scan_head_o.valid = start_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (in_data_i.req_type == REQ_DETECT) ? ST_SCAN : ST_WRITE;
        end
      end
      ST_WRITE: state_d = ST_DONE;
      ST_SCAN: begin
        if (scan_tail_i.valid) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign half_tune = cfg_i.buzz_tone[TMO_W-1:1];
  assign blink_inc = blink_q + 6'd1;

  always_comb begin
    offline_d = scan_tail_i.off;
    aset_d    = aset_q;
    aid_d     = aid_q;
    if (scan_tail_i.best_pri != '0) begin
      aset_d = 1'b1;
      aid_d  = scan_tail_i.best_id;
    end else if (scan_tail_i.off == '0) begin
      aset_d = 1'b0;
      aid_d  = '0;
    end

    blink_d = blink_q;
    fcnt_d  = fcnt_q;
    led_d   = led_q;
    beep_d  = '0;
    cls     = cfg_i.pattern_class[CLS_W*aid_d +: CLS_W];
    hit3    = 1'b0;
    hit5    = 1'b0;
    if (fault_q) begin
      fcnt_d = (fcnt_q > FAULT_WRAP) ? '0 : fcnt_q + 6'd1;
      beep_d = (fcnt_d < FAULT_ON_LIMIT) ? half_tune : '0;
    end else if (aset_d) begin
      blink_d = (blink_inc > BLINK_WRAP) ? '0 : blink_inc;
      hit3    = (blink_d == HIT_0) || (blink_d == HIT_1) || (blink_d == HIT_2);
      hit5    = hit3 || (blink_d == HIT_3) || (blink_d == HIT_4);
      if (cls == CLS_THREE) begin
        led_d  = hit3;
        beep_d = hit3 ? half_tune : '0;
      end else if (cls == CLS_FIVE) begin
        led_d  = hit5;
        beep_d = hit5 ? half_tune : '0;
      end else begin
        led_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      offline_q   <= '0;
      aset_q      <= 1'b0;
      aid_q       <= '0;
      blink_q     <= '0;
      fcnt_q      <= '0;
      led_q       <= 1'b0;
      beep_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      start_q <= accept && (in_data_i.req_type == REQ_DETECT);
      if (upd) begin
        offline_q <= offline_d;
        aset_q    <= aset_d;
        aid_q     <= aid_d;
        blink_q   <= blink_d;
        fcnt_q    <= fcnt_d;
        led_q     <= led_d;
        beep_q    <= beep_d;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q   <= in_data_i.now_ms[TIME_BITS-1:0];
      ch_q    <= in_data_i.channel;
      fault_q <= in_data_i.global_fault;
    end
    if (load_out) begin
      out_q.offline_mask  <= offline_q;
      out_q.alarm_valid   <= aset_q;
      out_q.alarm_channel <= aset_q ? aid_q : '0;
      out_q.led_red       <= led_q;
      out_q.beep_level    <= beep_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
